@@ rtl/egd_pkg.sv @@
// Shared constants, types and helpers for the Elias gamma/delta bit packer.
// Used by egd_norm, egd_packer and elias_gamma_delta_bit_packer_unit; no dependencies.
package egd_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int BYTE_BITS   = 8;
    localparam int CNT_W       = 4;
    localparam int ZW          = $clog2(VALUE_WIDTH);
    localparam int LW          = $clog2(VALUE_WIDTH + 1);
    localparam int DW          = LW + VALUE_WIDTH - 1;
    localparam int DCW         = $clog2(DW + 1);
    localparam int RW          = (DCW + 1 > 5) ? DCW + 1 : 5;
    localparam int SW          = (ZW > 1) ? $clog2(ZW) : 1;

    typedef enum logic [1:0] {
        PK_ENCODE,
        PK_FLUSH,
        PK_ERROR
    } t_pk_op;

    typedef struct packed {
        logic                   start;
        t_pk_op                 op;
        logic [ZW-1:0]          zero_cnt;
        logic [DCW-1:0]         data_cnt;
        logic [DW-1:0]          data;
    } t_pk_cmd;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] norm;
        logic [ZW-1:0]          lz;
    } t_norm_res;

    function automatic logic [LW-1:0] msb_pos(input logic [LW-1:0] x);
        logic [LW-1:0] pos;
        pos = '0;
        for (int i = 0; i < LW; i++) begin
            if (x[i]) begin
                pos = LW'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ rtl/elias_gamma_delta_bit_packer_unit.sv @@
// Top level of the Elias gamma/delta bit packer: input sequencer, code register,
// codeword setup. Depends on egd_pkg, egd_norm and egd_packer.
//
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    i_operation, i_value
// out      output     o_out_valid / i_out_stall  o_out_byte, o_bit_count, o_error, o_last
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_code_kind
//
// The packer is loaded at once for a flush or zero value, else when the normalizer is done;
// it then merges the zero run and the code bits into the accumulator, holding on output stalls.
// The input opens again once the packer has dropped busy and the sequencer has left S_WAIT.
// The block accepts one item at a time; o_in_stall is high until the packer is done.
// Reset is synchronous and active low and clears the accumulator and the code register.
module elias_gamma_delta_bit_packer_unit import egd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_operation,
    input  logic [31:0]            i_value,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_out_byte,
    output logic [CNT_W-1:0]       o_bit_count,
    output logic                   o_error,
    output logic                   o_last,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_code_kind
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } t_state;

    t_state                 r_state;
    logic                   r_code_kind;

    logic                   in_xfer;
    logic [VALUE_WIDTH-1:0] n_val;
    logic                   norm_start;
    t_norm_res              norm_res;
    t_pk_cmd                pk_cmd;
    logic                   pk_busy;
    logic [LW-1:0]          len;
    logic [LW-1:0]          msb;
    logic [LW-1:0]          len_norm;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign n_val       = i_value[VALUE_WIDTH-1:0];
    assign norm_start  = in_xfer && !i_operation && (n_val != '0);

    always_comb begin
        len      = LW'(VALUE_WIDTH) - LW'(norm_res.lz);
        msb      = msb_pos(len);
        len_norm = len << (LW'(LW - 1) - msb);

        pk_cmd.start    = 1'b0;
        pk_cmd.op       = PK_ENCODE;
        pk_cmd.zero_cnt = '0;
        pk_cmd.data_cnt = '0;
        pk_cmd.data     = '0;

        if (in_xfer && i_operation) begin
            pk_cmd.start = 1'b1;
            pk_cmd.op    = PK_FLUSH;
        end else if (in_xfer && (n_val == '0)) begin
            pk_cmd.start = 1'b1;
            pk_cmd.op    = PK_ERROR;
        end else if (r_state == S_SCAN && norm_res.done) begin
            pk_cmd.start = 1'b1;
            if (!r_code_kind) begin
                pk_cmd.zero_cnt = ZW'(len - LW'(1));
                pk_cmd.data_cnt = DCW'(len);
                pk_cmd.data     = {norm_res.norm, {(LW-1){1'b0}}};
            end else begin
                pk_cmd.zero_cnt = ZW'(msb);
                pk_cmd.data_cnt = DCW'(msb) + DCW'(len);
                pk_cmd.data     = {len_norm, {(VALUE_WIDTH-1){1'b0}}}
                                | ({norm_res.norm[VALUE_WIDTH-2:0], {LW{1'b0}}}
                                   >> (msb + LW'(1)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code_kind <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_code_kind <= i_cfg_code_kind;
            end
            case (r_state)
                S_IDLE: begin
                    if (norm_start) begin
                        r_state <= S_SCAN;
                    end else if (pk_cmd.start) begin
                        r_state <= S_WAIT;
                    end
                end
                S_SCAN: begin
                    if (norm_res.done) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (!pk_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    egd_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_value (n_val),
        .o_res   (norm_res)
    );

    egd_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (pk_cmd),
        .o_busy      (pk_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_bit_count (o_bit_count),
        .o_error     (o_error),
        .o_last      (o_last)
    );

endmodule

@@ rtl/egd_norm.sv @@
// Iterative normalizer: finds the leading-zero count of a nonzero value by a
// binary search, one shift-and-compare step per cycle. Depends on egd_pkg.
module egd_norm import egd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output t_norm_res              o_res
);

    localparam logic [SW-1:0] LAST_STEP = SW'(ZW - 1);

    logic                   r_busy;
    logic                   r_done;
    logic [SW-1:0]          r_step;
    logic [VALUE_WIDTH-1:0] r_v;
    logic [ZW-1:0]          r_z;

    logic [ZW-1:0]          s;
    logic [VALUE_WIDTH-1:0] mask;
    logic                   top_zero;

    always_comb begin
        s        = ZW'(1) << (LAST_STEP - r_step);
        mask     = ~({VALUE_WIDTH{1'b1}} >> s);
        top_zero = ((r_v & mask) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_v    <= i_value;
                r_z    <= '0;
            end else if (r_busy) begin
                if (top_zero) begin
                    r_v <= r_v << s;
                    r_z <= r_z + s;
                end
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + SW'(1);
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.norm = r_v;
    assign o_res.lz   = r_z;

endmodule

@@ rtl/egd_packer.sv @@
// Byte packer: merges zero runs and left-aligned code bits into the byte accumulator, at
// most one byte per cycle unless stalled, behind an output register. Depends on egd_pkg.
module egd_packer import egd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pk_cmd            i_cmd,
    output logic               o_busy,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_out_byte,
    output logic [CNT_W-1:0]   o_bit_count,
    output logic               o_error,
    output logic               o_last
);

    logic               r_busy;
    t_pk_op             r_op;
    logic [7:0]         r_acc;
    logic [2:0]         r_pend;
    logic [ZW-1:0]      r_zrem;
    logic [DCW-1:0]     r_drem;
    logic [DW-1:0]      r_data;
    logic               r_ov;
    logic [7:0]         r_obyte;
    logic [CNT_W-1:0]   r_ocnt;
    logic               r_oerr;
    logic               r_olast;

    logic               out_free;
    logic [RW-1:0]      room;
    logic [RW-1:0]      zrem_x;
    logic [RW-1:0]      drem_x;
    logic [RW-1:0]      k_x;
    logic [CNT_W-1:0]   k;
    logic [DW+7:0]      data_ext;
    logic [7:0]         bits8;
    logic [15:0]        acc_sh;
    logic [7:0]         acc_new;
    logic [CNT_W-1:0]   newp;
    logic [ZW-1:0]      n_zrem;
    logic [DCW-1:0]     n_drem;
    logic [RW-1:0]      left;

    always_comb begin
        out_free = !r_ov || !i_out_stall;
        room     = RW'(BYTE_BITS) - RW'(r_pend);
        zrem_x   = RW'(r_zrem);
        drem_x   = RW'(r_drem);
        data_ext = {r_data, 8'b0};
        n_zrem   = r_zrem;
        n_drem   = r_drem;
        if (r_zrem != '0) begin
            k_x    = (zrem_x < room) ? zrem_x : room;
            k      = k_x[CNT_W-1:0];
            bits8  = '0;
            n_zrem = r_zrem - ZW'(k);
        end else begin
            k_x    = (drem_x < room) ? drem_x : room;
            k      = k_x[CNT_W-1:0];
            bits8  = data_ext[DW+7 -: 8] >> (CNT_W'(BYTE_BITS) - k);
            n_drem = r_drem - DCW'(k);
        end
        acc_sh  = {8'b0, r_acc} << k;
        acc_new = acc_sh[7:0] | bits8;
        newp    = CNT_W'(r_pend) + k;
        left    = RW'(n_zrem) + RW'(n_drem);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= PK_ENCODE;
            r_acc  <= '0;
            r_pend <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (out_free) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_zrem <= i_cmd.zero_cnt;
                r_drem <= i_cmd.data_cnt;
                r_data <= i_cmd.data;
            end else if (r_busy && out_free) begin
                case (r_op)
                    PK_ERROR: begin
                        r_ov    <= 1'b1;
                        r_obyte <= '0;
                        r_ocnt  <= '0;
                        r_oerr  <= 1'b1;
                        r_olast <= 1'b1;
                        r_busy  <= 1'b0;
                    end
                    PK_FLUSH: begin
                        if (r_pend != '0) begin
                            r_ov    <= 1'b1;
                            r_obyte <= r_acc;
                            r_ocnt  <= CNT_W'(r_pend);
                            r_oerr  <= 1'b0;
                            r_olast <= 1'b1;
                        end
                        r_acc  <= '0;
                        r_pend <= '0;
                        r_busy <= 1'b0;
                    end
                    PK_ENCODE: begin
                        r_zrem <= n_zrem;
                        r_drem <= n_drem;
                        if (r_zrem == '0) begin
                            r_data <= r_data << k;
                        end
                        if (newp == CNT_W'(BYTE_BITS)) begin
                            r_ov    <= 1'b1;
                            r_obyte <= acc_new;
                            r_ocnt  <= CNT_W'(BYTE_BITS);
                            r_oerr  <= 1'b0;
                            r_olast <= (left < RW'(BYTE_BITS));
                            r_acc   <= '0;
                            r_pend  <= '0;
                        end else begin
                            r_acc  <= acc_new;
                            r_pend <= newp[2:0];
                        end
                        if (n_zrem == '0 && n_drem == '0) begin
                            r_busy <= 1'b0;
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_out_valid = r_ov;
    assign o_out_byte  = r_obyte;
    assign o_bit_count = r_ocnt;
    assign o_error     = r_oerr;
    assign o_last      = r_olast;

endmodule
